[hw/rtl/rmze_pkg.sv]
// ----------------------------------------------------------------------------
// rmze_pkg: shared types and constants for the ZYX Euler angle extractor
// Holds the payload structs, the arctangent table and the fixed angle codes.
// ----------------------------------------------------------------------------
package rmze_pkg;

    localparam int CordicStages    = 16;
    localparam int ElementFracBits = 14;
    localparam int MaxStages       = 32;

    // CORDIC datapath width: operands up to 2^26 scaled by 2^20, plus growth
    localparam int XyW = 50;
    // angle accumulator in 2^-16 degree
    localparam int ZW  = 26;
    // square accumulator: sum of two squares of 16-bit values, scaled by 2^16
    localparam int SqW = 50;
    localparam int HW  = 25;

    localparam logic signed [ZW-1:0] Deg180   = ZW'(11796480);
    localparam logic signed [15:0]   Deg90Out = 16'sd11520;
    localparam logic signed [15:0]   AngLimit = 16'sd23040;
    localparam logic [7:0]           MarginReset = 8'd7;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_POS  = 2'd1,
        LOCK_NEG  = 2'd2
    } t_lock;

    typedef struct packed {
        logic signed [15:0] elem_r0c0;
        logic signed [15:0] elem_r1c0;
        logic signed [15:0] elem_r2c0;
        logic signed [15:0] elem_r0c1;
        logic signed [15:0] elem_r1c1;
        logic signed [15:0] elem_r2c1;
        logic signed [15:0] elem_r2c2;
    } t_in;

    typedef struct packed {
        logic signed [15:0] angle_a;
        logic signed [15:0] angle_b;
        logic signed [15:0] angle_c;
        logic [1:0]         lock_case;
    } t_out;

    // one CORDIC lane between cells
    typedef struct packed {
        logic signed [XyW-1:0] x;
        logic signed [XyW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  zero;
    } t_lane;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // pre-rotation into the right half plane, then scale by 2^20
    function automatic t_lane lane_init(input logic signed [26:0] y,
                                        input logic signed [26:0] x);
        t_lane l;
        logic signed [XyW-1:0] xe;
        logic signed [XyW-1:0] ye;
        xe = XyW'(x);
        ye = XyW'(y);
        l.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            l.z = (y >= 0) ? Deg180 : -Deg180;
            xe = -xe;
            ye = -ye;
        end else begin
            l.z = '0;
        end
        l.x = xe <<< 20;
        l.y = ye <<< 20;
        return l;
    endfunction

    // round to 1/128 degree and saturate
    function automatic logic signed [15:0] lane_out(input t_lane l);
        logic signed [ZW:0] r;
        r = (ZW+1)'(l.z) + (ZW+1)'(256);
        r = r >>> 9;
        if (l.zero) begin
            return '0;
        end else if (r > (ZW+1)'(AngLimit)) begin
            return AngLimit;
        end else if (r < -(ZW+1)'(AngLimit)) begin
            return -AngLimit;
        end
        return 16'(r);
    endfunction

endpackage

[hw/rtl/rmze_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rmze_sqrt_cell: one step of the restoring square root
// Resolves one result bit and hands the remainder and the item on.
// ----------------------------------------------------------------------------
module rmze_sqrt_cell
    import rmze_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic [SqW-1:0] i_rem,
    input  logic [SqW-1:0] i_res,
    input  t_in            i_item,
    output logic [SqW-1:0] o_rem,
    output logic [SqW-1:0] o_res,
    output t_in            o_item
);
    localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2*STEP);

    logic [SqW-1:0] n_rem;
    logic [SqW-1:0] n_res;

    always_comb begin
        if (i_rem >= i_res + Bit) begin
            n_rem = i_rem - (i_res + Bit);
            n_res = (i_res >> 1) + Bit;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_res  <= n_res;
        o_item <= i_item;
    end
endmodule

[hw/rtl/rmze_cordic_cell.sv]
// ----------------------------------------------------------------------------
// rmze_cordic_cell: one vectoring micro-rotation on three lanes
// Rotates each lane towards the x axis and hands it to the next cell.
// ----------------------------------------------------------------------------
module rmze_cordic_cell
    import rmze_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic   i_clk,
    input  t_lane  i_lane [3],
    input  logic [15:0] i_side,
    output t_lane  o_lane [3],
    output logic [15:0] o_side
);
    localparam logic signed [ZW-1:0] Ang = atan_tab(STEP);

    t_lane n_lane [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k] = i_lane[k];
            if (i_lane[k].y < 0) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z - Ang;
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z + Ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_lane <= n_lane;
        o_side <= i_side;
    end
endmodule

[hw/rtl/rotation_matrix_to_zyx_euler.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_zyx_euler: ZYX Euler angles from a rotation matrix
// A start is taken every cycle that busy is low (busy is tied low). Each
// matrix flows through a chain of square root cells and then two chains of
// CORDIC cells (pitch first, then yaw and roll); the results strobe out
// in start order, one per cycle.
// The receiver cannot stall; results must be taken as they appear.
// ----------------------------------------------------------------------------
module rotation_matrix_to_zyx_euler
    import rmze_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStages
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  t_in        i_item,
    output logic       o_valid,
    output t_out       o_result
);
    localparam int SqSteps = SqW / 2;
    localparam int Lat = 1 + SqSteps + 1 + CORDIC_STAGES + 1 + CORDIC_STAGES + 1;

    logic [7:0]    r_margin;
    logic [Lat-1:0] r_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MarginReset;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) r_margin <= i_cfg_data;
            r_vld <= {r_vld[Lat-2:0], start};
        end
    end

    // square of the column-0 pair
    logic [SqW-1:0] r_sq;
    t_in            r_in;
    always_ff @(posedge i_clk) begin
        r_sq <= (SqW'(unsigned'(32'(i_item.elem_r0c0 * i_item.elem_r0c0)))
               + SqW'(unsigned'(32'(i_item.elem_r1c0 * i_item.elem_r1c0)))) << 16;
        r_in <= i_item;
    end

    logic [SqW-1:0] sq_rem [SqSteps+1];
    logic [SqW-1:0] sq_res [SqSteps+1];
    t_in            sq_item [SqSteps+1];
    assign sq_rem[0]  = r_sq;
    assign sq_res[0]  = '0;
    assign sq_item[0] = r_in;

    for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
        rmze_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_rem (sq_rem[g]),  .i_res (sq_res[g]),  .i_item (sq_item[g]),
            .o_rem (sq_rem[g+1]), .o_res (sq_res[g+1]), .o_item (sq_item[g+1])
        );
    end

    // pitch lane setup
    t_lane b_lane [CORDIC_STAGES+1][3];
    logic [15:0] b_unused [CORDIC_STAGES+1];
    t_in   r_bi;
    t_in   b_item [CORDIC_STAGES+1];
    logic  [HW-1:0] h;
    assign h = sq_res[SqSteps][HW-1:0];

    always_ff @(posedge i_clk) begin
        b_lane[0][0] <= lane_init(-(27'(sq_item[SqSteps].elem_r2c0) <<< 8),
                                  27'(signed'({1'b0, h})));
        b_lane[0][1] <= lane_init('0, '0);
        b_lane[0][2] <= lane_init('0, '0);
        r_bi         <= sq_item[SqSteps];
    end
    assign b_item[0]   = r_bi;
    assign b_unused[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_pitch
        rmze_cordic_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk), .i_lane (b_lane[g]), .i_side (b_unused[g]),
            .o_lane (b_lane[g+1]), .o_side (b_unused[g+1])
        );
        always_ff @(posedge i_clk) b_item[g+1] <= b_item[g];
    end

    // lock decision and setup of the yaw and roll lanes
    logic signed [15:0] ang_b;
    logic signed [16:0] dpos, dneg;
    t_lock lock;
    t_in   bi;
    assign ang_b = lane_out(b_lane[CORDIC_STAGES][0]);
    assign bi    = b_item[CORDIC_STAGES];
    always_comb begin
        dpos = 17'(ang_b) - 17'(Deg90Out);
        dneg = 17'(ang_b) + 17'(Deg90Out);
        if (dpos < 0) dpos = -dpos;
        if (dneg < 0) dneg = -dneg;
        if (dpos < 17'(r_margin))      lock = LOCK_POS;
        else if (dneg < 17'(r_margin)) lock = LOCK_NEG;
        else                           lock = LOCK_NONE;
    end

    t_lane c_lane [CORDIC_STAGES+1][3];
    logic [15:0] c_side [CORDIC_STAGES+1];
    logic [1:0]  r_lk;
    logic [1:0]  c_lk [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        c_lane[0][0] <= lane_init(27'(bi.elem_r1c0), 27'(bi.elem_r0c0));
        c_lane[0][1] <= (lock == LOCK_NONE)
                      ? lane_init(27'(bi.elem_r2c1), 27'(bi.elem_r2c2))
                      : lane_init(27'(bi.elem_r0c1), 27'(bi.elem_r1c1));
        c_lane[0][2] <= lane_init('0, '0);
        c_side[0]    <= ang_b;
        r_lk         <= lock;
    end
    assign c_lk[0] = r_lk;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_yaw
        rmze_cordic_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk), .i_lane (c_lane[g]), .i_side (c_side[g]),
            .o_lane (c_lane[g+1]), .o_side (c_side[g+1])
        );
        always_ff @(posedge i_clk) c_lk[g+1] <= c_lk[g];
    end

    // output register
    logic signed [15:0] ang_c;
    logic [1:0]         lk;
    assign ang_c = lane_out(c_lane[CORDIC_STAGES][1]);
    assign lk    = c_lk[CORDIC_STAGES];
    always_ff @(posedge i_clk) begin
        o_result.angle_b   <= c_side[CORDIC_STAGES];
        o_result.lock_case <= lk;
        o_result.angle_a   <= (lk == LOCK_NONE) ? lane_out(c_lane[CORDIC_STAGES][0]) : '0;
        o_result.angle_c   <= (lk == LOCK_NEG) ? -ang_c : ang_c;
    end
    assign o_valid = r_vld[Lat-1];
endmodule

[verif/rotation_matrix_to_zyx_euler_test.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_zyx_euler_test: self-checking regression for the block
// Drives directed and random matrices through the command port, predicts
// the ZYX angles and lock case for each transfer, and checks every strobed
// result in order against the oldest prediction. Margin is swept between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module rotation_matrix_to_zyx_euler_test;
    import rmze_pkg::*;

    localparam int Latency  = 2 + (SqW / 2) + 2 * CordicStages + 2;
    localparam int WdLimit  = 20 * Latency + 2000;
    localparam int NumItems = 800;

    localparam logic [27:0] ATan [0:15] = '{
        28'd2949120, 28'd1740967, 28'd919879, 28'd466945, 28'd234379,
        28'd117304, 28'd58666, 28'd29335, 28'd14668, 28'd7334, 28'd3667,
        28'd1833, 28'd917, 28'd458, 28'd229, 28'd115
    };

    // angle in 1/128 degree from a vectoring-mode rotation
    function automatic logic signed [15:0] vector_angle(input longint yi,
                                                        input longint xi);
        longint x, y, z, xs, ys, r;
        z = 0;
        if (xi == 0 && yi == 0) return 16'sd0;
        x = xi;
        y = yi;
        if (x < 0) begin
            z = (y >= 0) ? 11796480 : -11796480;
            x = -x;
            y = -y;
        end
        x = x * 1048576;
        y = y * 1048576;
        for (int i = 0; i < CordicStages; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATan[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATan[i]);
            end
        end
        r = (z + 256) >>> 9;
        if (r > 23040) r = 23040;
        if (r < -23040) r = -23040;
        return 16'(r);
    endfunction

    function automatic longint root_floor(input longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_out euler_predict(input t_in m, input logic [7:0] margin);
        t_out o;
        longint r00, r10, h, b;
        r00 = m.elem_r0c0;
        r10 = m.elem_r1c0;
        h = root_floor((r00 * r00 + r10 * r10) * 65536);
        o.angle_b = vector_angle(-longint'(m.elem_r2c0) * 256, h);
        b = o.angle_b;
        o.lock_case = LOCK_NONE;
        if ((b > 11520 ? b - 11520 : 11520 - b) < margin) o.lock_case = LOCK_POS;
        else if ((b > -11520 ? b + 11520 : -11520 - b) < margin) o.lock_case = LOCK_NEG;
        if (o.lock_case == LOCK_POS) begin
            o.angle_a = '0;
            o.angle_c = vector_angle(m.elem_r0c1, m.elem_r1c1);
        end else if (o.lock_case == LOCK_NEG) begin
            o.angle_a = '0;
            o.angle_c = -vector_angle(m.elem_r0c1, m.elem_r1c1);
        end else begin
            o.angle_a = vector_angle(m.elem_r1c0, m.elem_r0c0);
            o.angle_c = vector_angle(m.elem_r2c1, m.elem_r2c2);
        end
        return o;
    endfunction

    class angle_board;
        t_out pending[$];
        int   errors;
        logic [7:0] margin;

        function new();
            errors = 0;
            margin = MarginReset;
        endfunction

        function void note_matrix(t_in m);
            pending.push_back(euler_predict(m, margin));
        endfunction

        function void check_angles(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.angle_a !== w.angle_a) begin
                $error("angle_a exp %0d got %0d", w.angle_a, got.angle_a);
                errors++;
            end
            if (got.angle_b !== w.angle_b) begin
                $error("angle_b exp %0d got %0d", w.angle_b, got.angle_b);
                errors++;
            end
            if (got.angle_c !== w.angle_c) begin
                $error("angle_c exp %0d got %0d", w.angle_c, got.angle_c);
                errors++;
            end
            if (got.lock_case !== w.lock_case) begin
                $error("lock_case exp %0d got %0d", w.lock_case, got.lock_case);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;
    t_in  i_item = '0;
    logic o_valid;
    t_out o_result;

    angle_board board = new();
    int idle_cycles = 0;
    bit quiet = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rotation_matrix_to_zyx_euler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_angles(o_result);
        if (i_rst_n && ((start && !busy) || o_valid)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WdLimit) begin
            $display("rotation_matrix_to_zyx_euler regression: fail");
            $finish;
        end
    end

    // hold start high across back-to-back transfers, drop it only to idle
    task automatic send_matrix(input t_in m);
        while (!quiet && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_matrix(m);
    endtask

    task automatic set_margin(input logic [7:0] v);
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.margin = v;
    endtask

    function automatic logic signed [15:0] rnd16();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'sh7fff;
        if (k == 1) return 16'sh8000;
        if (k < 5) return 16'($urandom_range(32768)) - 16'sd16384;
        return 16'($urandom);
    endfunction

    // matrix from a random rotation, near or at a pole now and then
    function automatic t_in rnd_matrix();
        t_in m;
        real a, b, c, s;
        a = ($urandom_range(65535) / 65535.0 - 0.5) * 6.2831853;
        c = ($urandom_range(65535) / 65535.0 - 0.5) * 6.2831853;
        b = ($urandom_range(65535) / 65535.0 - 0.5) * 3.14159265;
        if ($urandom_range(3) == 0)
            b = ($urandom_range(1) ? 1.0 : -1.0) * (1.5707963 -
                $urandom_range(400) / 100000.0);
        s = 16384.0;
        m.elem_r0c0 = 16'($rtoi(s * $cos(a) * $cos(b)));
        m.elem_r1c0 = 16'($rtoi(s * $sin(a) * $cos(b)));
        m.elem_r2c0 = 16'($rtoi(-s * $sin(b)));
        m.elem_r0c1 = 16'($rtoi(s * ($cos(a) * $sin(b) * $sin(c) - $sin(a) * $cos(c))));
        m.elem_r1c1 = 16'($rtoi(s * ($sin(a) * $sin(b) * $sin(c) + $cos(a) * $cos(c))));
        m.elem_r2c1 = 16'($rtoi(s * $cos(b) * $sin(c)));
        m.elem_r2c2 = 16'($rtoi(s * $cos(b) * $cos(c)));
        return m;
    endfunction

    function automatic t_in noise_matrix();
        t_in m;
        m = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
        return m;
    endfunction

    initial begin
        t_in m;
        logic [7:0] margins [0:3] = '{8'd0, 8'd255, 8'd40, 8'd1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: zeros, extremes, identity, both poles, negative x
        send_matrix('0);
        send_matrix({7{16'sh7fff}});
        send_matrix({7{16'sh8000}});
        send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384});
        send_matrix({16'sd0, 16'sd0, -16'sd16384, 16'sd5000, 16'sd9000, 16'sd0, 16'sd0});
        send_matrix({16'sd0, 16'sd0, 16'sd16384, -16'sd5000, 16'sd9000, 16'sd0, 16'sd0});
        send_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, -16'sd16384});
        send_matrix({-16'sd100, -16'sd1, 16'sd3, 16'sd0, 16'sd0, -16'sd7, -16'sd9});
        send_matrix({16'sd1, 16'sd1, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                     16'sh7fff, 16'sh8000});
        for (int p = 0; p < 5; p++) begin
            if (p > 0) set_margin(margins[p-1]);
            for (int n = 0; n < NumItems / 5; n++) begin
                quiet = (n >= 60 && n < 100);
                m = ($urandom_range(99) < 80) ? rnd_matrix() : noise_matrix();
                send_matrix(m);
            end
        end
        quiet = 0;
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        if (board.errors == 0) $display("rotation_matrix_to_zyx_euler regression: pass");
        else $display("rotation_matrix_to_zyx_euler regression: fail");
        $finish;
    end
endmodule
